// ===== rtl/ultrasonic_echo_presence_detector_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ultrasonic echo presence detector
// Each macro expects signals named clock and reset in the calling scope.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_PRESENCE_DETECTOR_CORE_MACROS_SVH
`define ULTRASONIC_ECHO_PRESENCE_DETECTOR_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define UEPD_ASSERT_NOW(LABEL, ANTE, CONS) \
   LABEL: assert property (@(posedge clock) disable iff (reset) (ANTE) |-> (CONS)) \
      else $error("uepd: same-cycle check failed");

// next-cycle implication, checked out of reset
`define UEPD_ASSERT_NEXT(LABEL, ANTE, CONS) \
   LABEL: assert property (@(posedge clock) disable iff (reset) (ANTE) |=> (CONS)) \
      else $error("uepd: next-cycle check failed");

`endif

// ===== rtl/uepd_pkg.sv =====
// ----------------------------------------------------------------------------
// uepd_pkg
// Shared types, register indexes, reset values and constants of the
// ultrasonic echo presence detector.
// ----------------------------------------------------------------------------
`default_nettype none

package uepd_pkg;

   // field widths
   localparam int TIMEOUT_W  = 16;
   localparam int LIMIT_W    = 16;
   localparam int GAP_W      = 20;
   localparam int TRIGLEN_W  = 8;
   localparam int WIDTH_W    = 16;
   localparam int STATUS_W   = 2;
   localparam int DIST_W     = 19;
   localparam int DIST_MUL_W = 11;
   localparam int PROD_W     = WIDTH_W + DIST_MUL_W;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 20;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRES_LIM  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_GAP   = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIG_LEN  = 4'd3;

   // register reset values
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST  = 16'd30000;
   localparam logic [LIMIT_W-1:0]   PRES_LIM_RST = 16'd294;
   localparam logic [GAP_W-1:0]     MIN_GAP_RST  = 20'd60000;
   localparam logic [TRIGLEN_W-1:0] TRIG_LEN_RST = 8'd10;

   // gap counter saturation, distance scale (0.034/2 cm per us * 256 * 256)
   localparam logic [GAP_W-1:0]      GAP_MAX  = 20'hFFFFF;
   localparam logic [DIST_MUL_W-1:0] DIST_MUL = 11'd1114;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd2;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_TRIG,
      PH_RISE,
      PH_HIGH
   } phase_type;

   typedef struct packed {
      logic [TIMEOUT_W-1:0] timeout_us;
      logic [LIMIT_W-1:0]   presence_limit_us;
      logic [GAP_W-1:0]     min_gap_us;
      logic [TRIGLEN_W-1:0] trigger_len_us;
   } cfg_type;

   // result word, first field in the highest bits
   typedef struct packed {
      logic [DIST_W-1:0]   distance_cm_q8;
      logic [WIDTH_W-1:0]  echo_width_us;
      logic [STATUS_W-1:0] status;
      logic                done_res;
      logic                busy_res;
      logic                trigger;
   } rsp_word_type;

   localparam int RSP_W = $bits(rsp_word_type);

endpackage

`default_nettype wire

// ===== rtl/uepd_csr.sv =====
// ----------------------------------------------------------------------------
// uepd_csr
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module uepd_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [uepd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [uepd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output uepd_pkg::cfg_type                cfg
);
   import uepd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // decode write; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TIMEOUT:  cfg_in.timeout_us        = csr_wdata[TIMEOUT_W-1:0];
            CSR_PRES_LIM: cfg_in.presence_limit_us = csr_wdata[LIMIT_W-1:0];
            CSR_MIN_GAP:  cfg_in.min_gap_us        = csr_wdata[GAP_W-1:0];
            CSR_TRIG_LEN: cfg_in.trigger_len_us    = csr_wdata[TRIGLEN_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_us        <= TIMEOUT_RST;
         cfg_ff.presence_limit_us <= PRES_LIM_RST;
         cfg_ff.min_gap_us        <= MIN_GAP_RST;
         cfg_ff.trigger_len_us    <= TRIG_LEN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/uepd_ranger.sv =====
// ----------------------------------------------------------------------------
// uepd_ranger
// Measurement sequencer: request latch, gap timer, trigger pulse, echo
// rise and width timing, and the result word for each tick.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ultrasonic_echo_presence_detector_core_macros.svh"

module uepd_ranger (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_valid,
   input  logic                   start_req,
   input  logic                   echo,
   input  uepd_pkg::cfg_type      cfg,
   output uepd_pkg::rsp_word_type res
);
   import uepd_pkg::*;

   phase_type             phase_ff, phase_in, phase_next;
   logic                  pending_ff, pending_in, pending_next;
   logic [WIDTH_W-1:0]    phase_count_ff, phase_count_in, count_next;
   logic [GAP_W-1:0]      gap_count_ff, gap_count_in, gap_next;
   logic [WIDTH_W-1:0]    last_width_ff, last_width_in, width_next;
   logic [STATUS_W-1:0]   last_status_ff, last_status_in, status_next;
   logic [DIST_W-1:0]     last_dist_ff, last_dist_in, dist_next;

   logic                  pend;
   logic [TRIGLEN_W-1:0]  trig_len;
   logic                  gap_ok;
   logic                  trig_end;
   logic                  cnt_over;
   logic                  near;
   logic [PROD_W-1:0]     dist_prod;
   logic [DIST_W-1:0]     dist_new;
   logic                  trig;
   logic                  done;

   // conditions on the current state
   assign pend      = pending_ff | start_req;
   assign trig_len  = (cfg.trigger_len_us == '0) ? TRIGLEN_W'(1) : cfg.trigger_len_us;
   assign gap_ok    = gap_count_ff >= cfg.min_gap_us;
   assign trig_end  = phase_count_ff >= {{(WIDTH_W-TRIGLEN_W){1'b0}}, trig_len};
   assign cnt_over  = phase_count_ff >= cfg.timeout_us;
   assign near      = phase_count_ff < cfg.presence_limit_us;

   // distance of a width that ends now
   assign dist_prod = {{DIST_MUL_W{1'b0}}, phase_count_ff} *
                      {{WIDTH_W{1'b0}}, DIST_MUL};
   assign dist_new  = dist_prod[PROD_W-1:8];

   // next phase
   always_comb begin
      phase_next = phase_ff;
      unique case (phase_ff)
         PH_IDLE: if (pend && gap_ok) phase_next = PH_TRIG;
         PH_TRIG: if (trig_end) phase_next = PH_RISE;
         PH_RISE: begin
            if (echo) phase_next = PH_HIGH;
            else if (cnt_over) phase_next = PH_IDLE;
         end
         PH_HIGH: if (!echo || cnt_over) phase_next = PH_IDLE;
         default: phase_next = PH_IDLE;
      endcase
   end

   // counters, latched result and pin outputs
   always_comb begin
      pending_next = pend;
      count_next   = phase_count_ff;
      gap_next     = gap_count_ff;
      width_next   = last_width_ff;
      status_next  = last_status_ff;
      dist_next    = last_dist_ff;
      trig         = 1'b0;
      done         = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (pend && gap_ok) begin
               pending_next = 1'b0;
               count_next   = WIDTH_W'(1);
               trig         = 1'b1;
            end else if (gap_count_ff != GAP_MAX) begin
               gap_next = gap_count_ff + GAP_W'(1);
            end
         end
         PH_TRIG: begin
            if (trig_end) begin
               count_next = '0;
            end else begin
               count_next = phase_count_ff + WIDTH_W'(1);
               trig       = 1'b1;
            end
         end
         PH_RISE: begin
            if (echo) begin
               count_next = WIDTH_W'(1);
            end else if (cnt_over) begin
               status_next = ST_TIMEOUT;
               width_next  = '0;
               dist_next   = '0;
               count_next  = '0;
               gap_next    = '0;
               done        = 1'b1;
            end else begin
               count_next = phase_count_ff + WIDTH_W'(1);
            end
         end
         PH_HIGH: begin
            if (!echo) begin
               status_next = near ? ST_PRESENT : ST_ABSENT;
               width_next  = phase_count_ff;
               dist_next   = dist_new;
               count_next  = '0;
               gap_next    = '0;
               done        = 1'b1;
            end else if (cnt_over) begin
               status_next = ST_TIMEOUT;
               width_next  = '0;
               dist_next   = '0;
               count_next  = '0;
               gap_next    = '0;
               done        = 1'b1;
            end else begin
               count_next = phase_count_ff + WIDTH_W'(1);
            end
         end
         default: begin
            count_next = '0;
         end
      endcase
   end

   // state advances only on a tick
   assign phase_in       = step_valid ? phase_next   : phase_ff;
   assign pending_in     = step_valid ? pending_next : pending_ff;
   assign phase_count_in = step_valid ? count_next   : phase_count_ff;
   assign gap_count_in   = step_valid ? gap_next     : gap_count_ff;
   assign last_width_in  = step_valid ? width_next   : last_width_ff;
   assign last_status_in = step_valid ? status_next  : last_status_ff;
   assign last_dist_in   = step_valid ? dist_next    : last_dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         pending_ff     <= 1'b0;
         phase_count_ff <= '0;
         gap_count_ff   <= GAP_MAX;
         last_width_ff  <= '0;
         last_status_ff <= ST_PRESENT;
         last_dist_ff   <= '0;
      end else begin
         phase_ff       <= phase_in;
         pending_ff     <= pending_in;
         phase_count_ff <= phase_count_in;
         gap_count_ff   <= gap_count_in;
         last_width_ff  <= last_width_in;
         last_status_ff <= last_status_in;
         last_dist_ff   <= last_dist_in;
      end
   end

   // result word of this tick
   always_comb begin
      res.trigger        = trig;
      res.busy_res       = pending_next || (phase_next != PH_IDLE);
      res.done_res       = done;
      res.status         = status_next;
      res.echo_width_us  = width_next;
      res.distance_cm_q8 = dist_next;
   end

   // checks
   `UEPD_ASSERT_NEXT(a_done_restarts_gap, step_valid && res.done_res, gap_count_ff == '0)
   `UEPD_ASSERT_NOW(a_trigger_in_trig_phase, step_valid && res.trigger, phase_next == PH_TRIG)
   `UEPD_ASSERT_NOW(a_timeout_zero_width, last_status_ff == ST_TIMEOUT, last_width_ff == '0 && last_dist_ff == '0)

endmodule

`default_nettype wire

// ===== rtl/uepd_out_queue.sv =====
// ----------------------------------------------------------------------------
// uepd_out_queue
// Two-word result queue between the sequencer and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module uepd_out_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  uepd_pkg::rsp_word_type        push_word,
   output logic                          full,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [uepd_pkg::RSP_W-1:0]    rsp_tdata
);
   import uepd_pkg::*;

   rsp_word_type mem_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         pop;

   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = count_ff != 2'd0;
   assign full       = count_ff == 2'd2;
   assign rsp_tdata  = mem_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ultrasonic_echo_presence_detector_core.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_echo_presence_detector_core
// Ultrasonic ranging and presence detector, one sensor per instance.
//
//   channel  dir  handshake           word layout (low bit first)
//   req_     in   tvalid/tready       start_req, echo, 6 zero bits
//   rsp_     out  tvalid/tready       trigger, busy_res, done_res, status[2],
//                                     echo_width_us[16], distance_cm_q8[19]
//   csr_     in   we only             csr_index selects, csr_wdata holds value
//
// One word per cycle while the result queue has room: an input register,
// the sequencer logic, then a two-word result queue. A request is held in
// the input register, and its result word is valid once written into the queue.
// Synchronous reset returns all registers to their defaults.
// A stalled result side fills the queue; req_tready drops once the queue
// is full and the input register holds a word.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_echo_presence_detector_core (
   input  logic                             clock,
   input  logic                             reset,
   // request: start_req, echo
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,
   // result: trigger, busy_res, done_res, status, echo_width_us, distance_cm_q8
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [uepd_pkg::RSP_W-1:0]       rsp_tdata,
   // configuration
   input  logic                             csr_we,
   input  logic [uepd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [uepd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import uepd_pkg::*;

   cfg_type      cfg;
   rsp_word_type step_word;
   logic         q_full;
   logic         accept;
   logic         advance;
   logic         s1_valid_ff, s1_valid_in;
   logic         s1_start_ff, s1_start_in;
   logic         s1_echo_ff, s1_echo_in;

   // input register handshake
   assign advance    = s1_valid_ff && !q_full;
   assign req_tready = !s1_valid_ff || !q_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      s1_start_in = accept ? req_tdata[0] : s1_start_ff;
      s1_echo_in  = accept ? req_tdata[1] : s1_echo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_start_ff <= s1_start_in;
      s1_echo_ff  <= s1_echo_in;
   end

   uepd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   uepd_ranger u_ranger (
      .clock      (clock),
      .reset      (reset),
      .step_valid (advance),
      .start_req  (s1_start_ff),
      .echo       (s1_echo_ff),
      .cfg        (cfg),
      .res        (step_word)
   );

   uepd_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (advance),
      .push_word  (step_word),
      .full       (q_full),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// ===== verif/ultrasonic_echo_presence_detector_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ranging result checker
// Watches the request, result and register ports of the echo presence
// detector, runs its own tick-by-tick model of the ranging sequencer, and
// compares every accepted result word against the oldest predicted word.
// ----------------------------------------------------------------------------

module ultrasonic_echo_presence_detector_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // start_req, echo, 6 zero bits
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [uepd_pkg::RSP_W-1:0]      rsp_tdata,   // trigger, busy_res, done_res,
                                                        // status, echo_width_us,
                                                        // distance_cm_q8
   input  logic                            csr_we,
   input  logic [uepd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [uepd_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              mismatch_count,
   output int                              words_in_flight,
   output int                              present_seen,
   output int                              absent_seen,
   output int                              timeout_seen
);
   import uepd_pkg::*;

   // shadow registers and sequencer state
   cfg_type             regs;
   phase_type           ph;
   logic                pend;
   logic [WIDTH_W-1:0]  pcount;
   logic [GAP_W-1:0]    gcount;
   logic [WIDTH_W-1:0]  lwidth;
   logic [STATUS_W-1:0] lstatus;

   rsp_word_type expected_words[$];
   int errs, n_present, n_absent, n_timeout;

   // end of a measurement: latch the result and restart the gap count
   task automatic close_measurement(input logic [STATUS_W-1:0] st,
                                    input logic [WIDTH_W-1:0] w);
      lstatus = st;
      lwidth  = (st == ST_TIMEOUT) ? '0 : w;
      ph      = PH_IDLE;
      pcount  = '0;
      gcount  = '0;
   endtask

   // one microsecond tick of the ranging sequencer
   task automatic step_ranger(input logic start, input logic echo_lvl,
                              output rsp_word_type w);
      logic [TRIGLEN_W-1:0] len;
      logic                 trig;
      logic                 done;
      logic [31:0]          prod;
      trig = 1'b0;
      done = 1'b0;
      pend = pend | start;
      len  = (regs.trigger_len_us == '0) ? TRIGLEN_W'(1) : regs.trigger_len_us;
      case (ph)
         PH_TRIG: begin
            if (pcount >= len) begin
               ph     = PH_RISE;
               pcount = '0;
            end else begin
               pcount = pcount + 1'b1;
               trig   = 1'b1;
            end
         end
         PH_RISE: begin
            if (echo_lvl) begin
               ph     = PH_HIGH;
               pcount = WIDTH_W'(1);
            end else if (pcount >= regs.timeout_us) begin
               close_measurement(ST_TIMEOUT, '0);
               done = 1'b1;
            end else begin
               pcount = pcount + 1'b1;
            end
         end
         PH_HIGH: begin
            if (!echo_lvl) begin
               close_measurement((pcount < regs.presence_limit_us) ? ST_PRESENT : ST_ABSENT,
                                 pcount);
               done = 1'b1;
            end else if (pcount >= regs.timeout_us) begin
               close_measurement(ST_TIMEOUT, '0);
               done = 1'b1;
            end else begin
               pcount = pcount + 1'b1;
            end
         end
         default: begin
            ph = PH_IDLE;
            if (pend && gcount >= regs.min_gap_us) begin
               pend   = 1'b0;
               ph     = PH_TRIG;
               pcount = WIDTH_W'(1);
               trig   = 1'b1;
            end else if (gcount != GAP_MAX) begin
               gcount = gcount + 1'b1;
            end
         end
      endcase
      prod = 32'(lwidth) * 32'(DIST_MUL);
      w.trigger        = trig;
      w.busy_res       = pend || (ph != PH_IDLE);
      w.done_res       = done;
      w.status         = lstatus;
      w.echo_width_us  = lwidth;
      w.distance_cm_q8 = prod[DIST_W+7:8];
   endtask

   // sample all three ports at each edge
   always @(posedge clock) begin : watch
      rsp_word_type want;
      rsp_word_type got;
      rsp_word_type next_word;
      if (reset) begin
         regs.timeout_us        = TIMEOUT_RST;
         regs.presence_limit_us = PRES_LIM_RST;
         regs.min_gap_us        = MIN_GAP_RST;
         regs.trigger_len_us    = TRIG_LEN_RST;
         ph      = PH_IDLE;
         pend    = 1'b0;
         pcount  = '0;
         gcount  = GAP_MAX;
         lwidth  = '0;
         lstatus = ST_PRESENT;
         expected_words.delete();
      end else begin
         // register writes, unused indexes are dropped
         if (csr_we) begin
            case (csr_index)
               CSR_TIMEOUT:  regs.timeout_us        = csr_wdata[TIMEOUT_W-1:0];
               CSR_PRES_LIM: regs.presence_limit_us = csr_wdata[LIMIT_W-1:0];
               CSR_MIN_GAP:  regs.min_gap_us        = csr_wdata[GAP_W-1:0];
               CSR_TRIG_LEN: regs.trigger_len_us    = csr_wdata[TRIGLEN_W-1:0];
               default: ;
            endcase
         end

         // every accepted tick yields one result word
         if (req_tvalid && req_tready) begin
            step_ranger(req_tdata[0], req_tdata[1], next_word);
            expected_words.push_back(next_word);
         end

         // compare against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_words.size() == 0) begin
               errs++;
               $display("%0t: result word %h with nothing expected", $time, got);
            end else begin
               want = expected_words.pop_front();
               if (want.done_res) begin
                  case (want.status)
                     ST_PRESENT: n_present++;
                     ST_ABSENT:  n_absent++;
                     default:    n_timeout++;
                  endcase
               end
               if (got !== want) begin
                  errs++;
                  $display("%0t: expected trig=%0b busy=%0b done=%0b st=%0d w=%0d d=%0d",
                           $time, want.trigger, want.busy_res, want.done_res,
                           want.status, want.echo_width_us, want.distance_cm_q8);
                  $display("%0t: actual   trig=%0b busy=%0b done=%0b st=%0d w=%0d d=%0d",
                           $time, got.trigger, got.busy_res, got.done_res,
                           got.status, got.echo_width_us, got.distance_cm_q8);
               end
            end
         end
      end
      mismatch_count  <= errs;
      words_in_flight <= expected_words.size();
      present_seen    <= n_present;
      absent_seen     <= n_absent;
      timeout_seen    <= n_timeout;
   end

endmodule

// ===== verif/ultrasonic_echo_presence_detector_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echo presence detector testbench
// Drives microsecond ticks of request and echo level into the detector,
// first a short directed set at reset values and at zero and full-scale
// register values, then well-formed echo pulses mixed with pin noise under
// several register settings. Both stream sides idle at random. A separate
// checker predicts and compares every result word.
// ----------------------------------------------------------------------------

module ultrasonic_echo_presence_detector_core_test;
   import uepd_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 4'd9;
   localparam int TOTAL_TICKS      = 1350;
   localparam int SHARE_TICKS      = 260;
   localparam int EXTRA_TICKS      = 150;
   localparam int MIN_MEASUREMENTS = 48;
   localparam int SETTLE_CYCLES    = 8;
   localparam int DRAIN_LIMIT      = 5000;
   localparam int RUN_LIMIT_NS     = 10_000_000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = '0;    // start_req, echo, 6 zero bits
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;          // trigger, busy_res, done_res, status,
                                              // echo_width_us, distance_cm_q8
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int mismatch_count, words_in_flight, present_seen, absent_seen, timeout_seen;
   int req_idle_pct, rsp_stall_pct, rsp_stall_left, ticks_sent, settings_run;
   // current register values, only to shape pulse lengths
   int cur_timeout, cur_limit, cur_gap, cur_trig;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ultrasonic_echo_presence_detector_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   ultrasonic_echo_presence_detector_checker ranging_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .words_in_flight (words_in_flight),
      .present_seen    (present_seen),
      .absent_seen     (absent_seen),
      .timeout_seen    (timeout_seen)
   );

   // mostly short pauses, now and then a long one
   function automatic int pick_pause();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   // result side back-pressure
   always @(posedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_tready     <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
         rsp_tready     <= 1'b0;
         rsp_stall_left <= pick_pause();
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // one tick word, with an optional idle gap ahead of it
   task automatic send_tick(input logic start, input logic echo_lvl);
      int idle;
      idle = 0;
      if ($urandom_range(0, 99) < req_idle_pct) idle = pick_pause();
      if (idle > 0) begin
         req_tvalid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, echo_lvl, start};
      do @(posedge clock); while (!req_tready);
      ticks_sent++;
   endtask

   // hold the sender until every predicted word has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (words_in_flight != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all four registers, optionally also an unused index
   task automatic program_regs(input logic [CSR_DATA_W-1:0] t_val, l_val, g_val, n_val,
                               input bit with_spare);
      csr_we    <= 1'b1;
      csr_index <= CSR_TIMEOUT;
      csr_wdata <= t_val;
      @(posedge clock);
      csr_index <= CSR_PRES_LIM;
      csr_wdata <= l_val;
      @(posedge clock);
      csr_index <= CSR_MIN_GAP;
      csr_wdata <= g_val;
      @(posedge clock);
      csr_index <= CSR_TRIG_LEN;
      csr_wdata <= n_val;
      @(posedge clock);
      if (with_spare) begin
         csr_index <= CSR_SPARE;
         csr_wdata <= '1;
         @(posedge clock);
      end
      csr_we      <= 1'b0;
      cur_timeout = int'(t_val[TIMEOUT_W-1:0]);
      cur_limit   = int'(l_val[LIMIT_W-1:0]);
      cur_gap     = int'(g_val);
      cur_trig    = int'(n_val[TRIGLEN_W-1:0]);
      settings_run++;
   endtask

   // echo pulses with random timing, plus pin noise and lost echoes
   task automatic run_random_setting(input int budget, input bit need_results);
      int stop_at, kind, lead, width;
      stop_at = ticks_sent + budget;
      while (ticks_sent < stop_at ||
             (need_results && ticks_sent < stop_at + EXTRA_TICKS &&
              present_seen + absent_seen + timeout_seen < MIN_MEASUREMENTS)) begin
         req_idle_pct  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
         rsp_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            // request, trigger, rise wait, echo high, then the gap
            send_tick(1'b1, 1'b0);
            lead = cur_trig + (($urandom_range(0, 5) == 0) ? cur_timeout + 2
                                                           : $urandom_range(0, cur_timeout));
            repeat (lead) send_tick($urandom_range(0, 19) == 0, 1'b0);
            width = ($urandom_range(0, 4) == 0) ? cur_timeout + $urandom_range(0, 2)
                                                : $urandom_range(1, cur_limit * 2 + 2);
            repeat (width) send_tick(1'b0, 1'b1);
            repeat (cur_gap + $urandom_range(0, 3)) send_tick(1'b0, 1'b0);
         end else if (kind < 9) begin
            // pin and request noise
            repeat ($urandom_range(1, 30))
               send_tick($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)));
         end else begin
            // echo never comes back
            send_tick(1'b1, 1'b0);
            repeat (cur_trig + cur_timeout + 2) send_tick(1'b0, 1'b0);
         end
      end
   endtask

   initial begin : stimulus
      req_idle_pct  = 20;
      rsp_stall_pct = 20;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      cur_timeout = int'(TIMEOUT_RST);
      cur_limit   = int'(PRES_LIM_RST);
      cur_gap     = int'(MIN_GAP_RST);
      cur_trig    = int'(TRIG_LEN_RST);

      // reset values: saturated gap launches at once, single high sample
      send_tick(1'b1, 1'b0);
      repeat (10) send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);
      wait_drained();

      // full-scale timeout and limit, no gap, longest trigger
      program_regs(20'h0FFFF, 20'h0FFFF, 20'h00000, 20'h000FF, 1'b1);
      send_tick(1'b1, 1'b0);
      repeat (275) send_tick(1'b0, 1'b0);
      repeat (5) send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);
      wait_drained();

      // zero timeout, zero limit, no gap, zero trigger length (upper bits masked off)
      program_regs(20'hF0000, 20'h00000, 20'h00000, 20'hFFF00, 1'b0);
      // first low sample while waiting is a timeout
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b0);
      // second high sample is a timeout
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b1);
      // request while busy, then a one-sample echo that is not present
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);
      wait_drained();

      // largest gap: ticks with no request
      program_regs(20'h00028, 20'h00008, 20'hFFFFF, 20'h00003, 1'b0);
      repeat (8) send_tick(1'b0, 1'($urandom_range(0, 1)));
      wait_drained();

      // random pulses under a fixed and then random settings
      program_regs(20'd40, 20'd8, 20'd5, 20'd3, 1'b0);
      run_random_setting(SHARE_TICKS, 1'b0);
      wait_drained();
      repeat (2) begin
         program_regs(CSR_DATA_W'($urandom_range(1, 40)), CSR_DATA_W'($urandom_range(0, 30)),
                      CSR_DATA_W'($urandom_range(0, 20)), CSR_DATA_W'($urandom_range(0, 8)),
                      1'b0);
         run_random_setting(SHARE_TICKS, 1'b0);
         wait_drained();
      end
      program_regs(CSR_DATA_W'($urandom_range(1, 40)), CSR_DATA_W'($urandom_range(0, 30)),
                   CSR_DATA_W'($urandom_range(0, 20)), CSR_DATA_W'($urandom_range(0, 8)),
                   1'b0);
      run_random_setting((ticks_sent < TOTAL_TICKS) ? TOTAL_TICKS - ticks_sent : 1, 1'b1);

      // final drain, bounded
      req_tvalid <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < DRAIN_LIMIT && words_in_flight != 0; i++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (words_in_flight != 0)
         $display("%0t: %0d predicted result words never arrived", $time, words_in_flight);

      $display("covered %0d ticks under %0d register settings plus reset values",
               ticks_sent, settings_run);
      $display("measurements checked: %0d present, %0d not present, %0d timeout",
               present_seen, absent_seen, timeout_seen);
      if (mismatch_count == 0 && words_in_flight == 0) begin
         $display("ultrasonic_echo_presence_detector_core_test: done, clean");
      end else begin
         $display("ultrasonic_echo_presence_detector_core_test: done, errors");
      end
      $finish;
   end

   // hard stop for a hung run
   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("ultrasonic_echo_presence_detector_core_test: done, errors");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/uepd_pkg.sv
rtl/uepd_csr.sv
rtl/uepd_ranger.sv
rtl/uepd_out_queue.sv
rtl/ultrasonic_echo_presence_detector_core.sv
verif/ultrasonic_echo_presence_detector_checker.sv
verif/ultrasonic_echo_presence_detector_core_test.sv
